[rtl/core/usc_pkg.sv]
// ---------------------------------------------------------------------------
// usc_pkg
// Shared types and constants of the UTF-8 sanitizing copier.
// ---------------------------------------------------------------------------
package usc_pkg;

   localparam int MAX_CAPACITY = 256;
   localparam int CapW         = 9;
   localparam int MaxResults   = 5;
   localparam int ResCntW      = 3;
   localparam int QDepth       = 8;
   localparam int QCountW      = $clog2(QDepth + 1);

   localparam logic [CapW-1:0] CapReset = CapW'(64);

   // UTF-8 byte classes
   localparam logic [7:0] AsciiTop  = 8'h80;
   localparam logic [7:0] TwoLo     = 8'hc2;
   localparam logic [7:0] TwoHi     = 8'hdf;
   localparam logic [7:0] ThreeLo   = 8'he0;
   localparam logic [7:0] ThreeHi   = 8'hef;
   localparam logic [7:0] FourLo    = 8'hf0;
   localparam logic [7:0] FourHi    = 8'hf4;
   localparam logic [7:0] ContMask  = 8'hc0;
   localparam logic [7:0] ContTag   = 8'h80;
   localparam logic [7:0] LeadE0Min = 8'ha0;
   localparam logic [7:0] LeadEdMax = 8'ha0;
   localparam logic [7:0] LeadF0Min = 8'h90;
   localparam logic [7:0] LeadF4Max = 8'h90;
   localparam logic [7:0] LeadSurr  = 8'hed;
   localparam logic [7:0] ReplChar  = 8'h3f;
   localparam logic [7:0] TermByte  = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_string;
   } usc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_string;
      logic       all_valid;
   } usc_rsp_type;

   // results produced by one item
   typedef struct packed {
      logic [ResCntW-1:0]               n;
      usc_rsp_type [MaxResults-1:0]     slot;
   } usc_burst_type;

   typedef struct packed {
      logic [2:0][7:0]  pend;
      logic [1:0]       pcnt;
      logic [2:0]       elen;
      logic [CapW-1:0]  emitted;
      logic             saw_invalid;
      logic             stopped;
   } usc_state_type;

endpackage

[rtl/core/utf8_sanitizing_copier_unit.sv]
// ---------------------------------------------------------------------------
// utf8_sanitizing_copier_unit
// Copies a byte string while checking UTF-8; bad sequences become '?'.
// ---------------------------------------------------------------------------
// Channels: req_ carries one byte of a string per item (last_byte or
// empty_string closes the string); rsp_ carries the copied bytes, '?' per
// dropped byte, and finally a zero terminator with all_valid.
// csr_write_enable/csr_write_data set the output capacity (resets to 64),
// counted with the terminator. Write it only while the block is idle.
// An accepted item sits in the input register, is decoded combinationally,
// and its results are pushed into an 8-deep result queue once the queue
// has room; the head of the queue is offered on rsp_.
// Throughput: one item per cycle; one item yields 0 to 5 results, drained
// one per cycle. req_stall rises while the input register holds an item
// and the queue holds more than three results.
// Reset (synchronous) empties the queue and input register and clears the
// state but pend. While rsp_stall is high the queue holds its head item;
// it keeps absorbing items until its fill stops the input side.
// ---------------------------------------------------------------------------
module utf8_sanitizing_copier_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  usc_pkg::usc_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output usc_pkg::usc_rsp_type        rsp_data,
   input  logic                        csr_write_enable,
   input  logic [usc_pkg::CapW-1:0]    csr_write_data
);
   import usc_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   usc_req_type     in_item_ff;
   usc_state_type   state_ff;
   usc_state_type   state_in;
   logic [CapW-1:0] cap_ff;
   usc_burst_type   burst;
   logic            space_ok;
   logic            accept;
   logic            advance;

   assign advance   = in_valid_ff && space_ok;
   assign req_stall = in_valid_ff && !space_ok;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance) in_valid_in = 1'b0;
      if (accept) in_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_item_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_write_enable) begin
         cap_ff <= csr_write_data;
      end
   end

   usc_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .capacity   (cap_ff),
      .next_state (state_in),
      .burst      (burst)
   );

   // pending bytes are written before they are read; no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pcnt        <= '0;
         state_ff.elen        <= '0;
         state_ff.emitted     <= '0;
         state_ff.saw_invalid <= 1'b0;
         state_ff.stopped     <= 1'b0;
      end else if (advance) begin
         state_ff             <= state_in;
      end
   end

   usc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .burst     (burst),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a closing item always yields at least its terminator
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_item_ff.empty_string || in_item_ff.last_byte) |-> burst.n != '0)
      else $error("string end produced no terminator");

   // per-string state is cleared after the terminator
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_item_ff.empty_string || in_item_ff.last_byte) |=>
      state_ff.emitted == '0 && !state_ff.stopped && state_ff.pcnt == '0)
      else $error("string state not cleared after terminator");

   // a burst never exceeds the queue headroom reserved for it
   assert property (@(posedge clock) disable iff (reset)
      advance |-> burst.n <= ResCntW'(MaxResults))
      else $error("result burst too long");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

[rtl/core/usc_step.sv]
// ---------------------------------------------------------------------------
// usc_step
// Decode of one input byte against the string state: next state and the
// burst of result items it produces.
// ---------------------------------------------------------------------------
module usc_step (
   input  usc_pkg::usc_state_type      state,
   input  usc_pkg::usc_req_type        item,
   input  logic [usc_pkg::CapW-1:0]    capacity,
   output usc_pkg::usc_state_type      next_state,
   output usc_pkg::usc_burst_type      burst
);
   import usc_pkg::*;

   typedef struct packed {
      usc_state_type st;
      usc_burst_type bu;
   } work_type;

   logic [CapW-1:0] cap;
   work_type        w;
   logic            bad;
   logic [7:0]      lead;

   function automatic logic [2:0] seq_len(logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if (b < AsciiTop) len = 3'd1;
      else if (b >= TwoLo && b <= TwoHi) len = 3'd2;
      else if (b >= ThreeLo && b <= ThreeHi) len = 3'd3;
      else if (b >= FourLo && b <= FourHi) len = 3'd4;
      return len;
   endfunction

   function automatic logic has_room(work_type x, logic [2:0] k, logic [CapW-1:0] c);
      return ({1'b0, x.st.emitted} + (CapW+1)'(k)) < {1'b0, c};
   endfunction

   function automatic work_type put_byte(work_type x, logic [7:0] b, logic eos, logic ok);
      work_type r;
      r = x;
      if (r.bu.n < ResCntW'(MaxResults)) begin
         r.bu.slot[r.bu.n] = '{out_byte: b, end_of_string: eos, all_valid: ok};
         r.bu.n = r.bu.n + ResCntW'(1);
      end
      return r;
   endfunction

   function automatic work_type emit_repl(work_type x, logic [CapW-1:0] c);
      work_type r;
      r = x;
      if (!r.st.stopped) begin
         if (!has_room(r, 3'd1, c)) begin
            r.st.stopped = 1'b1;
         end else begin
            r = put_byte(r, ReplChar, 1'b0, 1'b0);
            r.st.emitted = r.st.emitted + CapW'(1);
            r.st.saw_invalid = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic work_type start_seq(work_type x, logic [7:0] b, logic [CapW-1:0] c);
      work_type   r;
      logic [2:0] len;
      r = x;
      len = seq_len(b);
      if (!r.st.stopped) begin
         if (!has_room(r, 3'd1, c)) begin
            r.st.stopped = 1'b1;
         end else if (len == 3'd0) begin
            r = emit_repl(r, c);
         end else if (len == 3'd1) begin
            r = put_byte(r, b, 1'b0, 1'b0);
            r.st.emitted = r.st.emitted + CapW'(1);
         end else begin
            r.st.pend[0] = b;
            r.st.pcnt = 2'd1;
            r.st.elen = len;
         end
      end
      return r;
   endfunction

   // one '?' per held byte of an unfinished sequence
   function automatic work_type drop_pending(work_type x, logic [CapW-1:0] c);
      work_type r;
      r = x;
      for (int i = 0; i < 3; i++) begin
         if (2'(i) < x.st.pcnt) r = emit_repl(r, c);
      end
      r.st.pcnt = 2'd0;
      r.st.elen = 3'd0;
      return r;
   endfunction

   always_comb begin
      cap = capacity;
      if (capacity == '0) cap = CapW'(1);
      if (32'(capacity) > 32'(MAX_CAPACITY)) cap = CapW'(MAX_CAPACITY);
   end

   assign lead = state.pend[0];

   always_comb begin
      bad = (item.data_byte & ContMask) != ContTag;
      if (!bad && state.pcnt == 2'd1) begin
         if (lead == ThreeLo && item.data_byte < LeadE0Min) bad = 1'b1;
         if (lead == LeadSurr && item.data_byte >= LeadEdMax) bad = 1'b1;
         if (lead == FourLo && item.data_byte < LeadF0Min) bad = 1'b1;
         if (lead == FourHi && item.data_byte >= LeadF4Max) bad = 1'b1;
      end
   end

   always_comb begin
      w.st = state;
      w.bu = '0;
      if (!item.empty_string && !state.stopped) begin
         if (state.pcnt == 2'd0) begin
            w = start_seq(w, item.data_byte, cap);
         end else if (bad) begin
            w = drop_pending(w, cap);
            w = start_seq(w, item.data_byte, cap);
         end else if ({1'b0, state.pcnt} + 3'd1 >= state.elen) begin
            // sequence complete: held bytes then this one, all or nothing
            if (!has_room(w, state.elen, cap)) begin
               w.st.stopped = 1'b1;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (2'(i) < state.pcnt) w = put_byte(w, state.pend[i], 1'b0, 1'b0);
               end
               w = put_byte(w, item.data_byte, 1'b0, 1'b0);
               w.st.emitted = state.emitted + CapW'(state.elen);
            end
            w.st.pcnt = 2'd0;
            w.st.elen = 3'd0;
         end else begin
            w.st.pend[state.pcnt] = item.data_byte;
            w.st.pcnt = state.pcnt + 2'd1;
         end
      end
      if (item.empty_string || item.last_byte) begin
         if (w.st.pcnt != 2'd0) w = drop_pending(w, cap);
         w = put_byte(w, TermByte, 1'b1, !w.st.saw_invalid);
         w.st.pcnt        = 2'd0;
         w.st.elen        = 3'd0;
         w.st.emitted     = '0;
         w.st.saw_invalid = 1'b0;
         w.st.stopped     = 1'b0;
      end
   end

   assign next_state = w.st;
   assign burst      = w.bu;

endmodule

[rtl/core/usc_queue.sv]
// ---------------------------------------------------------------------------
// usc_queue
// Shift queue of result items: takes a burst of up to five items at once,
// hands out one item per cycle from its head while rsp_stall is low.
// ---------------------------------------------------------------------------
module usc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  usc_pkg::usc_burst_type  burst,
   output logic                    space_ok,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output usc_pkg::usc_rsp_type    rsp_data
);
   import usc_pkg::*;

   usc_rsp_type          entry_ff [QDepth];
   usc_rsp_type          entry_in [QDepth];
   logic [QCountW-1:0]   count_ff;
   logic [QCountW-1:0]   count_in;
   logic [QCountW-1:0]   base;
   logic                 pop;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign space_ok  = count_ff <= QCountW'(QDepth - MaxResults);
   assign base      = count_ff - QCountW'(pop);

   always_comb begin
      for (int i = 0; i < QDepth; i++) begin
         if (pop && i < QDepth - 1) entry_in[i] = entry_ff[(i + 1) % QDepth];
         else entry_in[i] = entry_ff[i];
         if (push && QCountW'(i) >= base &&
             (QCountW+1)'(i) < (QCountW+1)'(base) + (QCountW+1)'(burst.n)) begin
            entry_in[i] = burst.slot[ResCntW'(QCountW'(i) - base)];
         end
      end
      count_in = base + (push ? QCountW'(burst.n) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
